// ----- sv/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fdp_pkg.sv -----
// shared types, constants and the step program of the pid datapath
package fdp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DEN_W      = 34;
    localparam int NUM_STEPS  = 21;
    localparam int STEP_W     = 5;

    typedef logic signed [47:0] q48_t;

    localparam q48_t MAX48 = {1'b0, {47{1'b1}}};
    localparam q48_t MIN48 = {1'b1, {47{1'b0}}};

    // multiplier operand sources
    typedef enum logic [4:0] {
        SRC_WEIGHT,
        SRC_KI_EFF,
        SRC_KP,
        SRC_KD,
        SRC_KITS,
        SRC_G,
        SRC_TF,
        SRC_TS,
        SRC_T2PTS,
        SRC_T2MTS,
        SRC_TSMT2,
        SRC_R0,
        SRC_R1,
        SRC_R2,
        SRC_EP0,
        SRC_EP1,
        SRC_EP2,
        SRC_EI0,
        SRC_EI1,
        SRC_EI2,
        SRC_ED0,
        SRC_ED1,
        SRC_ED2,
        SRC_PC0,
        SRC_PC1
    } src_t;

    // where a product goes
    typedef enum logic [2:0] {
        DST_EP0,
        DST_EP1,
        DST_EP2,
        DST_KITS,
        DST_G,
        DST_ACC
    } dst_t;

    // integer weight of a term added to the sum
    typedef enum logic [2:0] {
        SCL_P1,
        SCL_P2,
        SCL_P4,
        SCL_P8,
        SCL_M8
    } scl_t;

    typedef struct packed {
        src_t a;
        src_t b;
        dst_t dst;
        scl_t scl;
    } uop_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic mul_start;
        logic div_start;
        logic commit;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic out_busy;
    } sts_t;

    // one product per step, summed terms carry their weight
    function automatic uop_t step_uop(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            5'd0:    u = '{SRC_WEIGHT, SRC_R0,    DST_EP0,  SCL_P1};
            5'd1:    u = '{SRC_WEIGHT, SRC_R1,    DST_EP1,  SCL_P1};
            5'd2:    u = '{SRC_WEIGHT, SRC_R2,    DST_EP2,  SCL_P1};
            5'd3:    u = '{SRC_KI_EFF, SRC_TS,    DST_KITS, SCL_P1};
            5'd4:    u = '{SRC_KP,     SRC_T2PTS, DST_G,    SCL_P1};
            5'd5:    u = '{SRC_G,      SRC_EP0,   DST_ACC,  SCL_P2};
            5'd6:    u = '{SRC_KP,     SRC_TF,    DST_G,    SCL_P1};
            5'd7:    u = '{SRC_G,      SRC_EP1,   DST_ACC,  SCL_M8};
            5'd8:    u = '{SRC_KP,     SRC_T2MTS, DST_G,    SCL_P1};
            5'd9:    u = '{SRC_G,      SRC_EP2,   DST_ACC,  SCL_P2};
            5'd10:   u = '{SRC_KITS,   SRC_T2PTS, DST_G,    SCL_P1};
            5'd11:   u = '{SRC_G,      SRC_EI0,   DST_ACC,  SCL_P1};
            5'd12:   u = '{SRC_KITS,   SRC_TS,    DST_G,    SCL_P1};
            5'd13:   u = '{SRC_G,      SRC_EI1,   DST_ACC,  SCL_P2};
            5'd14:   u = '{SRC_KITS,   SRC_TSMT2, DST_G,    SCL_P1};
            5'd15:   u = '{SRC_G,      SRC_EI2,   DST_ACC,  SCL_P1};
            5'd16:   u = '{SRC_KD,     SRC_ED0,   DST_ACC,  SCL_P4};
            5'd17:   u = '{SRC_KD,     SRC_ED1,   DST_ACC,  SCL_M8};
            5'd18:   u = '{SRC_KD,     SRC_ED2,   DST_ACC,  SCL_P4};
            5'd19:   u = '{SRC_TF,     SRC_PC0,   DST_ACC,  SCL_P8};
            5'd20:   u = '{SRC_TSMT2,  SRC_PC1,   DST_ACC,  SCL_P2};
            default: u = '{SRC_KP,     SRC_TS,    DST_G,    SCL_P1};
        endcase
        return u;
    endfunction

endpackage

// ----- sv/fdp_mul.sv -----
// q32.16 multiplier: four 24x24 partial products, floor shift and 48 bit saturation
module fdp_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  fdp_pkg::q48_t a,
    input  fdp_pkg::q48_t b,
    output logic          done,
    output fdp_pkg::q48_t result
);
    import fdp_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_PP0  = 3'd1;
    localparam logic [2:0] PH_PP1  = 3'd2;
    localparam logic [2:0] PH_PP2  = 3'd3;
    localparam logic [2:0] PH_PP3  = 3'd4;
    localparam logic [2:0] PH_RND  = 3'd5;
    localparam logic [2:0] PH_SAT  = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic        done_reg, done_next;
    logic [47:0] ma_reg, mb_reg;
    logic        neg_reg;
    logic [95:0] acc_reg;
    logic [79:0] q_reg;
    q48_t        res_reg;

    logic [1:0]  pp_idx;
    logic [23:0] pa, pb;
    logic [47:0] pp;
    logic [95:0] pp_sh;

    always_comb
    begin
        pp_idx = 2'(phase_reg - PH_PP0);
        pa     = pp_idx[1] ? ma_reg[47:24] : ma_reg[23:0];
        pb     = pp_idx[0] ? mb_reg[47:24] : mb_reg[23:0];
        pp     = 48'(pa) * 48'(pb);
        case (pp_idx)
            2'd0:    pp_sh = {48'b0, pp};
            2'd3:    pp_sh = {pp, 48'b0};
            default: pp_sh = {24'b0, pp, 24'b0};
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            PH_IDLE: phase_next = start ? PH_PP0 : PH_IDLE;
            PH_PP0:  phase_next = PH_PP1;
            PH_PP1:  phase_next = PH_PP2;
            PH_PP2:  phase_next = PH_PP3;
            PH_PP3:  phase_next = PH_RND;
            PH_RND:  phase_next = PH_SAT;
            PH_SAT:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
        done_next = (phase_reg == PH_SAT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            ma_reg  <= a[47] ? 48'(-a) : a;
            mb_reg  <= b[47] ? 48'(-b) : b;
            neg_reg <= a[47] ^ b[47];
            acc_reg <= '0;
        end
        else if (phase_reg == PH_PP0 || phase_reg == PH_PP1 ||
                 phase_reg == PH_PP2 || phase_reg == PH_PP3)
        begin
            acc_reg <= acc_reg + pp_sh;
        end

        // negative products round the magnitude up, which is floor on the signed value
        if (phase_reg == PH_RND)
            q_reg <= acc_reg[95:16] + 80'(neg_reg && (acc_reg[15:0] != 16'h0));

        if (phase_reg == PH_SAT)
        begin
            if (q_reg[79:47] != '0)
                res_reg <= neg_reg ? MIN48 : MAX48;
            else if (neg_reg)
                res_reg <= q48_t'(-q_reg[47:0]);
            else
                res_reg <= q48_t'(q_reg[47:0]);
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- sv/fdp_div.sv -----
// radix-2 restoring divider: (num * 2^16) / den, truncated toward zero, saturated to 48 bits
module fdp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  fdp_pkg::q48_t             num,
    input  logic [fdp_pkg::DEN_W-1:0] den,
    output logic                      done,
    output fdp_pkg::q48_t             quo
);
    import fdp_pkg::*;

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_RUN  = 2'd1;
    localparam logic [1:0] DV_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [63:0]      dvd_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [63:0]      q_reg;
    logic             neg_reg;
    q48_t             quo_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[63]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = DV_RUN;
                    cnt_next   = '0;
                end
            end
            DV_RUN:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = DV_FIN;
            end
            DV_FIN:  state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
        done_next = (state_reg == DV_FIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && start)
        begin
            dvd_reg <= {(num[47] ? 48'(-num) : 48'(num)), 16'h0};
            rem_reg <= '0;
            q_reg   <= '0;
            den_reg <= den;
            neg_reg <= num[47];
        end
        else if (state_reg == DV_RUN)
        begin
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            q_reg   <= {q_reg[62:0], ge};
        end

        if (state_reg == DV_FIN)
        begin
            if (q_reg[63:47] != '0)
                quo_reg <= neg_reg ? MIN48 : MAX48;
            else if (neg_reg)
                quo_reg <= q48_t'(-q_reg[47:0]);
            else
                quo_reg <= q48_t'(q_reg[47:0]);
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- sv/fdp_datapath.sv -----
// pid datapath: config registers, history, operand select, multiplier, divider, clamp
module fdp_datapath #(
    parameter int unsigned SAMPLE_PERIOD_Q16 = 655
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fdp_pkg::cmd_t                  cmd,
    output fdp_pkg::sts_t                  sts,
    input  logic                           cfg_wr_en,
    input  logic [fdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [31:0]                    s_axis_tdata,   // setpoint [15:0], measured [31:16]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // drive [7:0]
    output logic                           m_axis_tuser    // saturated [0]
);
    import fdp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_WEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_ENABLE    = 3'd7;

    localparam logic [15:0] TS16 = 16'(SAMPLE_PERIOD_Q16);
    localparam q48_t        TS48 = {32'h0, TS16};

    // configuration
    logic signed [31:0] kp_reg, ki_reg, kd_reg, bw_reg;
    logic [30:0]        tf_reg;
    logic signed [7:0]  ulim_reg, llim_reg;
    logic               clamp_en_reg;

    // history and per-word state
    logic signed [15:0] ps0_reg, ps1_reg, pm0_reg, pm1_reg;
    q48_t               pc0_reg, pc1_reg;
    logic               integral_on_reg, integral_on_next;
    logic signed [15:0] cur_sp_reg, cur_ms_reg;

    // terms derived from the filter time
    q48_t               t2pts_reg, t2mts_reg, tsmt2_reg;
    logic [DEN_W-1:0]   den_reg;

    // intermediate values
    q48_t               ep0_reg, ep1_reg, ep2_reg, kits_reg, g_reg;
    q48_t               term_reg;
    logic               term_add_reg;
    logic signed [51:0] acc_reg;

    // output word
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         drive_reg;
    logic               sat_reg;

    q48_t               opa, opb, mul_res, div_quo, sum48;
    logic               mul_done, div_done;
    q48_t               tf48, tf2;

    logic signed [51:0] m52, scaled, ep_wide;
    logic signed [15:0] wb_y;

    q48_t               hi48, lo48, u48;
    logic               over, under, sat_now;
    logic [7:0]         t8;

    function automatic q48_t sat48(input logic signed [51:0] x);
        if (x[51:47] == 5'b00000 || x[51:47] == 5'b11111)
            return q48_t'(x[47:0]);
        else
            return x[51] ? MIN48 : MAX48;
    endfunction

    function automatic q48_t pos16(input logic signed [15:0] v);
        return {{16{v[15]}}, v, 16'h0};
    endfunction

    function automatic q48_t err16(input logic signed [15:0] r, input logic signed [15:0] y);
        logic signed [16:0] d;
        d = {r[15], r} - {y[15], y};
        return {{15{d[16]}}, d, 16'h0};
    endfunction

    function automatic q48_t src_val(input src_t s);
        q48_t v;
        case (s)
            SRC_WEIGHT: v = {{16{bw_reg[31]}}, bw_reg};
            SRC_KI_EFF: v = integral_on_reg ? {{16{ki_reg[31]}}, ki_reg} : '0;
            SRC_KP:     v = {{16{kp_reg[31]}}, kp_reg};
            SRC_KD:     v = {{16{kd_reg[31]}}, kd_reg};
            SRC_KITS:   v = kits_reg;
            SRC_G:      v = g_reg;
            SRC_TF:     v = tf48;
            SRC_TS:     v = TS48;
            SRC_T2PTS:  v = t2pts_reg;
            SRC_T2MTS:  v = t2mts_reg;
            SRC_TSMT2:  v = tsmt2_reg;
            SRC_R0:     v = pos16(cur_sp_reg);
            SRC_R1:     v = pos16(ps0_reg);
            SRC_R2:     v = pos16(ps1_reg);
            SRC_EP0:    v = ep0_reg;
            SRC_EP1:    v = ep1_reg;
            SRC_EP2:    v = ep2_reg;
            SRC_EI0:    v = err16(cur_sp_reg, cur_ms_reg);
            SRC_EI1:    v = err16(ps0_reg, pm0_reg);
            SRC_EI2:    v = err16(ps1_reg, pm1_reg);
            SRC_ED0:    v = err16(16'sh0, cur_ms_reg);
            SRC_ED1:    v = err16(16'sh0, pm0_reg);
            SRC_ED2:    v = err16(16'sh0, pm1_reg);
            SRC_PC0:    v = pc0_reg;
            SRC_PC1:    v = pc1_reg;
            default:    v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        tf48 = {17'h0, tf_reg};
        tf2  = {16'h0, tf_reg, 1'b0};
        opa  = src_val(cmd.uop.a);
        opb  = src_val(cmd.uop.b);
    end

    fdp_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (opa),
        .b      (opb),
        .done   (mul_done),
        .result (mul_res)
    );

    assign sum48 = sat48(acc_reg);

    fdp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (sum48),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // product write-back
    always_comb
    begin
        m52 = {{4{mul_res[47]}}, mul_res};
        case (cmd.uop.scl)
            SCL_P1:  scaled = m52;
            SCL_P2:  scaled = m52 <<< 1;
            SCL_P4:  scaled = m52 <<< 2;
            SCL_P8:  scaled = m52 <<< 3;
            SCL_M8:  scaled = 52'sd0 - (m52 <<< 3);
            default: scaled = m52;
        endcase
        case (cmd.uop.dst)
            DST_EP1: wb_y = pm0_reg;
            DST_EP2: wb_y = pm1_reg;
            default: wb_y = cur_ms_reg;
        endcase
        ep_wide = m52 - {{20{wb_y[15]}}, wb_y, 16'h0};
    end

    // clamp of the new control value
    always_comb
    begin
        hi48    = {{24{ulim_reg[7]}}, ulim_reg, 16'h0};
        lo48    = {{24{llim_reg[7]}}, llim_reg, 16'h0};
        over    = (div_quo > hi48);
        under   = (div_quo < lo48);
        sat_now = over || under;
        u48     = over ? hi48 : (under ? lo48 : div_quo);
        // integer part truncated toward zero, low byte only
        t8      = u48[23:16] + 8'(u48[47] && (u48[15:0] != 16'h0));
        integral_on_next = sat_now ? !clamp_en_reg : 1'b1;
        out_valid_next   = cmd.commit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg          <= '0;
            ki_reg          <= '0;
            kd_reg          <= '0;
            tf_reg          <= 31'd1310720;
            bw_reg          <= 32'sd65536;
            ulim_reg        <= '0;
            llim_reg        <= '0;
            clamp_en_reg    <= 1'b0;
            ps0_reg         <= '0;
            ps1_reg         <= '0;
            pm0_reg         <= '0;
            pm1_reg         <= '0;
            pc0_reg         <= '0;
            pc1_reg         <= '0;
            integral_on_reg <= 1'b1;
            term_add_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:       kp_reg       <= cfg_data;
                    CFG_INTEGRAL_GAIN:   ki_reg       <= cfg_data;
                    CFG_DERIV_GAIN:      kd_reg       <= cfg_data;
                    CFG_FILTER_TIME:     tf_reg       <= cfg_data[30:0];
                    CFG_SETPOINT_WEIGHT: bw_reg       <= cfg_data;
                    CFG_UPPER_LIMIT:     ulim_reg     <= cfg_data[7:0];
                    CFG_LOWER_LIMIT:     llim_reg     <= cfg_data[7:0];
                    CFG_CLAMP_ENABLE:    clamp_en_reg <= cfg_data[0];
                    default:             ;
                endcase
            end
            if (cmd.commit)
            begin
                ps1_reg         <= ps0_reg;
                ps0_reg         <= cur_sp_reg;
                pm1_reg         <= pm0_reg;
                pm0_reg         <= cur_ms_reg;
                pc1_reg         <= pc0_reg;
                pc0_reg         <= div_quo;
                integral_on_reg <= integral_on_next;
            end
            term_add_reg  <= mul_done && (cmd.uop.dst == DST_ACC);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t2pts_reg <= tf2 + TS48;
        t2mts_reg <= tf2 - TS48;
        tsmt2_reg <= TS48 - tf2;
        den_reg   <= {1'b0, tf_reg, 2'b00} + {17'h0, TS16, 1'b0};

        if (cmd.capture)
        begin
            cur_sp_reg <= s_axis_tdata[15:0];
            cur_ms_reg <= s_axis_tdata[31:16];
        end

        if (mul_done)
        begin
            case (cmd.uop.dst)
                DST_EP0:  ep0_reg  <= sat48(ep_wide);
                DST_EP1:  ep1_reg  <= sat48(ep_wide);
                DST_EP2:  ep2_reg  <= sat48(ep_wide);
                DST_KITS: kits_reg <= mul_res;
                DST_G:    g_reg    <= mul_res;
                DST_ACC:  term_reg <= sat48(scaled);
                default:  ;
            endcase
        end

        // terms pass through term_reg and term_add_reg before they land in the sum
        if (cmd.clear)
            acc_reg <= '0;
        else if (term_add_reg)
            acc_reg <= acc_reg + {{4{term_reg[47]}}, term_reg};

        if (cmd.commit)
        begin
            drive_reg <= 8'h0 - t8;
            sat_reg   <= sat_now;
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.out_busy = out_valid_reg && !m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = drive_reg;
    assign m_axis_tuser  = sat_reg;

endmodule

// ----- sv/fdp_ctrl.sv -----
// controller: steps the product program, starts the divider, hands off the result word
module fdp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  fdp_pkg::sts_t sts,
    output fdp_pkg::cmd_t cmd
);
    import fdp_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL_GO   = 3'd1;
    localparam logic [2:0] ST_MUL_WAIT = 3'd2;
    localparam logic [2:0] ST_SUM      = 3'd3;
    localparam logic [2:0] ST_DIV_GO   = 3'd4;
    localparam logic [2:0] ST_DIV_WAIT = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;

    assign accept = (state_reg == ST_IDLE) && s_axis_tvalid;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_MUL_GO;
                    step_next  = '0;
                end
            end
            ST_MUL_GO:   state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
            begin
                if (sts.mul_done)
                begin
                    if (step_reg == LAST_STEP)
                        state_next = ST_SUM;
                    else
                    begin
                        state_next = ST_MUL_GO;
                        step_next  = step_reg + STEP_W'(1);
                    end
                end
            end
            // lets the last term reach the sum
            ST_SUM:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cmd.capture   = accept;
        cmd.clear     = accept;
        cmd.mul_start = (state_reg == ST_MUL_GO);
        cmd.div_start = (state_reg == ST_DIV_GO);
        cmd.commit    = (state_reg == ST_OUT) && !sts.out_busy;
        cmd.uop       = step_uop(step_reg);
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

endmodule

// ----- sv/filtered_two_dof_pid.sv -----
// filtered two-dof pid controller, top level
// words are handled one at a time: a new word is accepted only once the last one is committed
// each word takes 21 products on the one shared 24x24 multiplier, then the bit-serial
// divider and the sequencing states
// the output register holds a finished word while the next one is accepted
// rst_n clears config to defaults, history to zero, integral enable to one
`include "assert_macros.svh"

module filtered_two_dof_pid #(
    parameter int unsigned SAMPLE_PERIOD_Q16 = 655
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,   // setpoint [15:0], measured [31:16]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // drive [7:0]
    output logic                           m_axis_tuser,   // saturated [0]
    input  logic                           cfg_wr_en,
    input  logic [fdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fdp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    fdp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    fdp_datapath #(
        .SAMPLE_PERIOD_Q16 (SAMPLE_PERIOD_Q16)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `ASSERT_SAME(a_commit_free, cmd.commit, !sts.out_busy, "result word overwritten")
    `ASSERT_SAME(a_done_excl, sts.mul_done, !sts.div_done, "multiplier and divider done together")
    `ASSERT_NEXT(a_one_word, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken")
    `ASSERT_SAME(a_valid_src, $rose(m_axis_tvalid), $past(cmd.commit), "output valid without commit")

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for the filtered two-dof pid controller, self-checking against a built-in predictor
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned TICK_Q16 = 655;
    localparam longint Q_MAX = longint'(fdp_pkg::MAX48);
    localparam longint Q_MIN = longint'(fdp_pkg::MIN48);
    localparam longint ONE_Q16 = 65536;

    typedef enum logic [fdp_pkg::CFG_IDX_W-1:0] {
        REG_KP,
        REG_KI,
        REG_KD,
        REG_TF,
        REG_WEIGHT,
        REG_UPPER,
        REG_LOWER,
        REG_CLAMP
    } reg_idx_t;

    typedef struct {
        logic signed [15:0] setpoint;
        logic signed [15:0] measured;
    } tick_t;

    typedef struct {
        logic [7:0] drive;
        logic       saturated;
    } ctrl_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [fdp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fdp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // register mirror, reset values
    longint cfg_kp = 0;
    longint cfg_ki = 0;
    longint cfg_kd = 0;
    longint cfg_tf = 1310720;
    longint cfg_weight = 65536;
    longint cfg_upper = 0;
    longint cfg_lower = 0;
    logic   cfg_clamp = 1'b0;

    // controller history
    longint hist_sp[2] = '{0, 0};
    longint hist_meas[2] = '{0, 0};
    longint hist_ctrl[2] = '{0, 0};
    logic   integ_on = 1'b1;

    tick_t      ticks_q[$];
    ctrl_word_t control_q[$];
    int         ticks_queued = 0;
    int         ticks_taken = 0;
    int         mismatches = 0;
    int         send_idle_pct = 29;
    int         recv_idle_pct = 59;
    int         trk_sp = 0;
    int         trk_meas = 0;

    filtered_two_dof_pid #(
        .SAMPLE_PERIOD_Q16(TICK_Q16)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint clip48(longint x);
        if (x > Q_MAX)
            return Q_MAX;
        if (x < Q_MIN)
            return Q_MIN;
        return x;
    endfunction

    // q32.16 product, floored, saturated to 48 bits
    function automatic longint qmul16(longint a, longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] prod;
        wa = 128'(a);
        wb = 128'(b);
        prod = (wa * wb) >>> 16;
        if (prod > Q_MAX)
            return Q_MAX;
        if (prod < Q_MIN)
            return Q_MIN;
        return longint'(prod);
    endfunction

    // one control tick: updates the history and returns the drive word
    function automatic ctrl_word_t compute_control(logic signed [15:0] sp,
                                                   logic signed [15:0] meas);
        longint r[3];
        longint y[3];
        longint ep[3];
        longint ei[3];
        longint ed[3];
        longint ts;
        longint tf2;
        longint ki_eff;
        longint kits;
        longint acc;
        longint den;
        longint v0;
        longint hi;
        longint lo;
        longint u;
        longint whole;
        ctrl_word_t res;
        ts = longint'(TICK_Q16);
        tf2 = cfg_tf * 2;
        ki_eff = integ_on ? cfg_ki : 0;
        r[0] = longint'(sp);
        r[1] = hist_sp[0];
        r[2] = hist_sp[1];
        y[0] = longint'(meas);
        y[1] = hist_meas[0];
        y[2] = hist_meas[1];
        for (int i = 0; i < 3; i++)
        begin
            ep[i] = clip48(qmul16(cfg_weight, r[i] * ONE_Q16) - y[i] * ONE_Q16);
            ei[i] = (r[i] - y[i]) * ONE_Q16;
            ed[i] = -(y[i] * ONE_Q16);
        end
        kits = qmul16(ki_eff, ts);

        acc = 0;
        acc += clip48(qmul16(qmul16(cfg_kp, tf2 + ts), ep[0]) * 2);
        acc += clip48(qmul16(qmul16(cfg_kp, cfg_tf), ep[1]) * -8);
        acc += clip48(qmul16(qmul16(cfg_kp, tf2 - ts), ep[2]) * 2);
        acc += qmul16(qmul16(kits, ts + tf2), ei[0]);
        acc += clip48(qmul16(qmul16(kits, ts), ei[1]) * 2);
        acc += qmul16(qmul16(kits, ts - tf2), ei[2]);
        acc += clip48(qmul16(cfg_kd, ed[0]) * 4);
        acc += clip48(qmul16(cfg_kd, ed[1]) * -8);
        acc += clip48(qmul16(cfg_kd, ed[2]) * 4);
        acc += clip48(qmul16(cfg_tf, hist_ctrl[0]) * 8);
        acc += clip48(qmul16(ts - tf2, hist_ctrl[1]) * 2);
        acc = clip48(acc);

        den = cfg_tf * 4 + ts * 2;
        v0 = clip48((acc * ONE_Q16) / den);

        hist_ctrl[1] = hist_ctrl[0];
        hist_ctrl[0] = v0;
        hist_sp[1] = hist_sp[0];
        hist_sp[0] = r[0];
        hist_meas[1] = hist_meas[0];
        hist_meas[0] = y[0];

        hi = cfg_upper * ONE_Q16;
        lo = cfg_lower * ONE_Q16;
        // upper limit wins when the limits are crossed
        if (v0 > hi || v0 < lo)
        begin
            u = (v0 > hi) ? hi : lo;
            integ_on = !cfg_clamp;
            res.saturated = 1'b1;
        end
        else
        begin
            u = v0;
            integ_on = 1'b1;
            res.saturated = 1'b0;
        end
        whole = u / ONE_Q16;
        res.drive = 8'(-whole);
        return res;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        tick_t next_tick;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                control_q.push_back(compute_control(s_axis_tdata[15:0], s_axis_tdata[31:16]));
                ticks_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (ticks_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_tick = ticks_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {next_tick.measured, next_tick.setpoint};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        ctrl_word_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (control_q.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual drive %0d saturated %0b",
                             $time, $signed(m_axis_tdata), m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = control_q.pop_front();
                    if (m_axis_tdata !== want.drive)
                    begin
                        $display("%0t: drive mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.drive), $signed(m_axis_tdata));
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.saturated)
                    begin
                        $display("%0t: saturated mismatch: expected %0b, actual %0b",
                                 $time, want.saturated, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_KP:     cfg_kp = longint'($signed(val));
            REG_KI:     cfg_ki = longint'($signed(val));
            REG_KD:     cfg_kd = longint'($signed(val));
            REG_TF:     cfg_tf = longint'(val[30:0]);
            REG_WEIGHT: cfg_weight = longint'($signed(val));
            REG_UPPER:  cfg_upper = longint'($signed(val[7:0]));
            REG_LOWER:  cfg_lower = longint'($signed(val[7:0]));
            REG_CLAMP:  cfg_clamp = val[0];
            default:    ;
        endcase
    endtask

    task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                             logic [31:0] tf, logic [31:0] weight, logic [31:0] upper,
                             logic [31:0] lower, logic [31:0] clamp);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_TF, tf);
        write_reg(REG_WEIGHT, weight);
        write_reg(REG_UPPER, upper);
        write_reg(REG_LOWER, lower);
        write_reg(REG_CLAMP, clamp);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_tick(logic [15:0] sp, logic [15:0] meas);
        tick_t tk;
        tk.setpoint = sp;
        tk.measured = meas;
        ticks_q.push_back(tk);
        ticks_queued++;
    endtask

    task automatic wait_drained();
        while (ticks_taken != ticks_queued || control_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int clamp_pos(int x);
        if (x > 32767)
            return 32767;
        if (x < -32768)
            return -32768;
        return x;
    endfunction

    // mostly a measurement chasing a wandering setpoint, some full-range noise
    task automatic queue_random_ticks(int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 12)
            begin
                push_tick(16'($urandom), 16'($urandom));
            end
            else
            begin
                if ($urandom_range(19) == 0)
                    trk_sp = clamp_pos(trk_sp + int'($urandom_range(0, 10000)) - 5000);
                else
                    trk_sp = clamp_pos(trk_sp + int'($urandom_range(0, 64)) - 32);
                trk_meas = clamp_pos(trk_meas + (trk_sp - trk_meas) / 4
                                     + int'($urandom_range(0, 6)) - 3);
                push_tick(16'(trk_sp), 16'(trk_meas));
            end
        end
    endtask

    function automatic logic [31:0] rand_gain(int span_q16);
        logic [31:0] mag;
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default:
            begin
                mag = $urandom_range(0, span_q16);
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_filter_time();
        logic [31:0] tf;
        case ($urandom_range(9))
            0: tf = 32'h0;
            1: tf = 32'h7fff_ffff;
            2: tf = 32'h1;
            default: tf = $urandom_range(1, 40 * 65536);
        endcase
        // bit 31 lies outside the register
        tf[31] = 1'($urandom_range(1));
        return tf;
    endfunction

    task automatic write_random_config();
        logic [31:0] upper;
        logic [31:0] lower;
        upper = $urandom;
        lower = $urandom;
        if ($urandom_range(9) < 7)
        begin
            upper[7:0] = 8'($urandom_range(0, 127));
            lower[7:0] = 8'(-$urandom_range(0, 128));
        end
        write_all(rand_gain(4 * 65536), rand_gain(16 * 65536), rand_gain(65536),
                  rand_filter_time(), rand_gain(2 * 65536), upper, lower, $urandom);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset configuration, plain extremes of the inputs
        push_tick(16'sd0, 16'sd0);
        push_tick(16'sd32767, -16'sd32768);
        wait_drained();

        write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0014_0000,
                  32'h0001_0000, 32'd100, -32'sd100, 32'd0);
        push_tick(16'sd0, 16'sd0);
        push_tick(16'sd32767, -16'sd32768);
        push_tick(-16'sd32768, 16'sd32767);
        push_tick(16'sd32767, 16'sd32767);
        push_tick(-16'sd32768, -16'sd32768);
        push_tick(16'sd1, 16'sd0);
        push_tick(16'sd0, 16'sd1);
        push_tick(-16'sd1, -16'sd1);
        wait_drained();

        // crossed limits, zero filter time, integral cut by clamping
        write_all(32'h0002_0000, 32'h0004_0000, 32'h0, 32'h0,
                  32'h0000_c000, -32'sd5, 32'd5, 32'd1);
        push_tick(16'sd100, 16'sd0);
        push_tick(-16'sd100, 16'sd0);
        push_tick(16'sd0, 16'sd0);
        push_tick(16'sd50, 16'sd50);
        push_tick(16'sd3, 16'sd0);
        push_tick(-16'sd3, 16'sd0);
        wait_drained();

        // both limits at -128, so the drive wraps to 0x80
        write_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                  32'h8000_0000, 32'hffff_ff80, 32'h0000_0080, 32'hffff_fffe);
        push_tick(-16'sd32768, 16'sd32767);
        push_tick(16'sd32767, -16'sd32768);
        push_tick(16'sd0, 16'sd0);
        push_tick(16'sd12345, -16'sd12345);
        push_tick(-16'sd1, 16'sd1);
        wait_drained();

        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 59;
            end
            else if (phase < 5)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 0)
                write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
                          32'h7fff_ffff, 32'h7f, 32'h7f, 32'h1);
            else if (phase == 1)
                write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                          32'h8000_0000, 32'h7f, 32'h80, 32'h0);
            else
                write_random_config();
            queue_random_ticks(100);
            wait_drained();
        end

        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
